>>> hw/rtl/qau_pkg.sv
`default_nettype none

package qau_pkg;

    // operation codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_SCALE    = 4'd4,
        MODE_SCALEDIV = 4'd5,
        MODE_NEG      = 4'd6,
        MODE_CONJ     = 4'd7,
        MODE_INV      = 4'd8,
        MODE_NORM     = 4'd9,
        MODE_LEN      = 4'd10,
        MODE_LENSQ    = 4'd11
    } mode_t;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale;
    } op_item_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic [30:0]        magnitude;
        logic               zero_divide;
    } res_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/quaternion_arithmetic_unit.sv
`default_nettype none

// Quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// (Q16.16 by default). One operation per transaction: add, sub, Hamilton
// product, divide, scale, scalar divide, negate, conjugate, inverse,
// normalise, length and squared length. Quaternion results saturate to 32
// bits and magnitudes to 31 bits. The unit is a 72-stage pipeline and takes
// one transaction every cycle while the output is not stalled, whatever the
// mode. The depth is set by the square root (32 stages, one root bit each)
// and the restoring divider after it (34 stages: setup, one per quotient
// bit, result). A two-deep output (last stage plus a skid register) holds
// a result not taken; op_ready is low while the skid register is full.
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    output logic                     op_ready,
    input  wire qau_pkg::op_item_t   op,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output qau_pkg::res_item_t       res
);

    localparam int F   = FRAC_BITS;
    localparam int SQW = 64 - F;     // floor(a*a / 2^F), non-negative
    localparam int NW  = 65 - F;     // squared norm, also the divisor width
    localparam int PW  = 64 - F;     // floor(a*b / 2^F), signed
    localparam int HW  = PW + 2;     // sum of four products
    localparam logic [30:0] MAG_MAX = 31'h7fff_ffff;

    typedef logic [3:0][31:0] quat_t;   // [0]=w [1]=x [2]=y [3]=z

    typedef struct packed {
        logic [3:0]    mode;
        quat_t         a;
        quat_t         b;
        logic [31:0]   s;
        logic [NW-1:0] n_a;
        logic [NW-1:0] n_b;
        logic          zd;
    } sq_side_t;

    typedef struct packed {
        logic [3:0]  mode;
        quat_t       a;
        quat_t       b;
        logic [31:0] s;
        logic        zd;
        logic [30:0] mag;
    } dv_side_t;

    // saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat_h(logic [HW-1:0] v);
        logic [HW-32:0] top;
        top = v[HW-1:31];
        if (top == '0 || top == '1)
        begin
            return v[31:0];
        end
        return v[HW-1] ? qau_pkg::SAT_MIN : qau_pkg::SAT_MAX;
    endfunction

    function automatic logic [HW-1:0] ext33(logic [32:0] v);
        return {{(HW-33){v[32]}}, v};
    endfunction

    function automatic logic [HW-1:0] ext_p(logic [PW-1:0] v);
        return {{2{v[PW-1]}}, v};
    endfunction

    // optional negate, then split into sign and magnitude
    function automatic logic [32:0] num_prep(logic [31:0] v, logic inv);
        logic [32:0] e;
        logic [32:0] m;
        e = inv ? (~{v[31], v} + 33'd1) : {v[31], v};
        m = e[32] ? (~e + 33'd1) : e;
        return {e[32], m[31:0]};
    endfunction

    // pipeline advance and output skid
    logic en;
    logic skid_valid_reg;
    qau_pkg::res_item_t skid_reg;

    // stage 0: input register
    logic              v0_reg;
    qau_pkg::op_item_t op0_reg;

    // stage 1: squares
    logic              v1_reg;
    qau_pkg::op_item_t op1_reg;
    logic [SQW-1:0]    sqa_reg [4];
    logic [SQW-1:0]    sqb_reg [4];
    logic [SQW-1:0]    sqa_next [4];
    logic [SQW-1:0]    sqb_next [4];

    // stage 2: norms, zero-divisor flag, root operand
    logic              v2_reg;
    sq_side_t          side2_reg;
    logic [63:0]       t2_reg;
    sq_side_t          side2_next;
    logic [63:0]       t2_next;

    // square root
    logic              v_sq;
    logic [31:0]       root;
    logic [$bits(sq_side_t)-1:0] side_sq_bits;
    sq_side_t          side_sq;

    // stage 3: divider operands, magnitude
    logic              v3_reg;
    dv_side_t          side3_reg;
    logic [3:0][31:0]  dmag_reg;
    logic [3:0]        dneg_reg;
    logic [NW-1:0]     dden_reg;
    logic              dden_neg_reg;
    dv_side_t          side3_next;
    logic [3:0][31:0]  dmag_next;
    logic [3:0]        dneg_next;
    logic [NW-1:0]     dden_next;
    logic              dden_neg_next;

    // divider
    logic              v_dv;
    quat_t             dq;
    logic [$bits(dv_side_t)-1:0] side_dv_bits;
    dv_side_t          side_dv;

    // stage 4: product bank
    logic              v4_reg;
    dv_side_t          side4_reg;
    quat_t             q4_reg;
    logic [PW-1:0]     pr_reg  [4][4];
    logic [PW-1:0]     pr_next [4][4];

    // stage 5: sums, saturation, result select
    logic               v5_reg;
    qau_pkg::res_item_t res5_reg;
    qau_pkg::res_item_t res5_next;

    assign en       = !skid_valid_reg;
    assign op_ready = en;

    // ---------------- stage 1 ----------------
    always_comb
    begin
        quat_t              qa;
        quat_t              qb;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        qa = {op0_reg.a_z, op0_reg.a_y, op0_reg.a_x, op0_reg.a_w};
        qb = {op0_reg.b_z, op0_reg.b_y, op0_reg.b_x, op0_reg.b_w};
        for (int i = 0; i < 4; i++)
        begin
            pa = $signed(qa[i]) * $signed(qa[i]);
            pb = $signed(qb[i]) * $signed(qb[i]);
            sqa_next[i] = pa[63:F];
            sqb_next[i] = pb[63:F];
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        logic [NW-1:0] na;
        logic [NW-1:0] nb;
        na = NW'(sqa_reg[0]) + NW'(sqa_reg[1]) + NW'(sqa_reg[2]) + NW'(sqa_reg[3]);
        nb = NW'(sqb_reg[0]) + NW'(sqb_reg[1]) + NW'(sqb_reg[2]) + NW'(sqb_reg[3]);
        side2_next.mode = op1_reg.mode;
        side2_next.a    = {op1_reg.a_z, op1_reg.a_y, op1_reg.a_x, op1_reg.a_w};
        side2_next.b    = {op1_reg.b_z, op1_reg.b_y, op1_reg.b_x, op1_reg.b_w};
        side2_next.s    = op1_reg.scale;
        side2_next.n_a  = na;
        side2_next.n_b  = nb;
        // a non-zero norm always gives a non-zero length, so the norm decides
        case (op1_reg.mode)
            qau_pkg::MODE_DIV:      side2_next.zd = (nb == '0);
            qau_pkg::MODE_SCALEDIV: side2_next.zd = (op1_reg.scale == '0);
            qau_pkg::MODE_INV:      side2_next.zd = (na == '0);
            qau_pkg::MODE_NORM:     side2_next.zd = (na == '0);
            default:                side2_next.zd = 1'b0;
        endcase
        // n * 2^F clamps to all ones only when n sits at its ceiling
        t2_next = na[NW-1] ? '1 : {na[NW-2:0], {F{1'b0}}};
    end

    qau_sqrt_pipe #(
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_t      (t2_reg),
        .in_side   (side2_reg),
        .out_valid (v_sq),
        .out_root  (root),
        .out_side  (side_sq_bits)
    );

    assign side_sq = side_sq_bits;

    // ---------------- stage 3 ----------------
    always_comb
    begin
        logic [32:0] p;
        logic [31:0] s_mag;
        s_mag = side_sq.s[31] ? (~side_sq.s + 32'd1) : side_sq.s;

        side3_next.mode = side_sq.mode;
        side3_next.a    = side_sq.a;
        side3_next.b    = side_sq.b;
        side3_next.s    = side_sq.s;
        side3_next.zd   = side_sq.zd;
        case (side_sq.mode)
            qau_pkg::MODE_LEN:   side3_next.mag = root[31] ? MAG_MAX : root[30:0];
            qau_pkg::MODE_LENSQ: side3_next.mag = (|side_sq.n_a[NW-1:31]) ? MAG_MAX
                                                                          : side_sq.n_a[30:0];
            default:             side3_next.mag = '0;
        endcase

        dden_neg_next = 1'b0;
        case (side_sq.mode)
            qau_pkg::MODE_DIV:      dden_next = side_sq.n_b;
            qau_pkg::MODE_SCALEDIV:
            begin
                dden_next     = NW'(s_mag);
                dden_neg_next = side_sq.s[31];
            end
            qau_pkg::MODE_INV:      dden_next = side_sq.n_a;
            default:                dden_next = NW'(root);
        endcase

        for (int l = 0; l < 4; l++)
        begin
            case (side_sq.mode)
                qau_pkg::MODE_DIV: p = num_prep(side_sq.b[l], l != 0);
                qau_pkg::MODE_INV: p = num_prep(side_sq.a[l], l != 0);
                default:           p = num_prep(side_sq.a[l], 1'b0);
            endcase
            dneg_next[l] = p[32];
            dmag_next[l] = p[31:0];
        end
    end

    qau_div_pipe #(
        .F      (F),
        .DW     (NW),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v3_reg),
        .in_num_mag (dmag_reg),
        .in_num_neg (dneg_reg),
        .in_den     (dden_reg),
        .in_den_neg (dden_neg_reg),
        .in_side    (side3_reg),
        .out_valid  (v_dv),
        .out_q      (dq),
        .out_side   (side_dv_bits)
    );

    assign side_dv = side_dv_bits;

    // ---------------- stage 4 ----------------
    // scaling runs through the Hamilton bank with B = (s, 0, 0, 0)
    always_comb
    begin
        quat_t              m;
        logic signed [63:0] prod;
        case (side_dv.mode)
            qau_pkg::MODE_MUL: m = side_dv.b;
            qau_pkg::MODE_DIV: m = dq;
            default:           m = {32'd0, 32'd0, 32'd0, side_dv.s};
        endcase
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod = $signed(side_dv.a[i]) * $signed(m[j]);
                pr_next[i][j] = prod[63:F];
            end
        end
    end

    // ---------------- stage 5 ----------------
    always_comb
    begin
        logic [HW-1:0] hw;
        logic [HW-1:0] hx;
        logic [HW-1:0] hy;
        logic [HW-1:0] hz;
        quat_t         a;
        quat_t         b;
        quat_t         h;
        quat_t         r;
        logic [30:0]   mag;
        a  = side4_reg.a;
        b  = side4_reg.b;
        hw = ext_p(pr_reg[0][0]) - ext_p(pr_reg[1][1]) - ext_p(pr_reg[2][2])
           - ext_p(pr_reg[3][3]);
        hx = ext_p(pr_reg[2][3]) - ext_p(pr_reg[3][2]) + ext_p(pr_reg[0][1])
           + ext_p(pr_reg[1][0]);
        hy = ext_p(pr_reg[3][1]) - ext_p(pr_reg[1][3]) + ext_p(pr_reg[0][2])
           + ext_p(pr_reg[2][0]);
        hz = ext_p(pr_reg[1][2]) - ext_p(pr_reg[2][1]) + ext_p(pr_reg[0][3])
           + ext_p(pr_reg[3][0]);
        h  = {sat_h(hz), sat_h(hy), sat_h(hx), sat_h(hw)};
        r   = '0;
        mag = '0;
        case (side4_reg.mode)
            qau_pkg::MODE_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r[i] = sat_h(ext33({a[i][31], a[i]} + {b[i][31], b[i]}));
                end
            end
            qau_pkg::MODE_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r[i] = sat_h(ext33({a[i][31], a[i]} - {b[i][31], b[i]}));
                end
            end
            qau_pkg::MODE_MUL:      r = h;
            qau_pkg::MODE_SCALE:    r = h;
            qau_pkg::MODE_DIV:      r = side4_reg.zd ? '0 : h;
            qau_pkg::MODE_SCALEDIV: r = side4_reg.zd ? '0 : q4_reg;
            qau_pkg::MODE_INV:      r = side4_reg.zd ? '0 : q4_reg;
            qau_pkg::MODE_NORM:     r = side4_reg.zd ? '0 : q4_reg;
            qau_pkg::MODE_NEG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r[i] = sat_h(ext33(33'd0 - {a[i][31], a[i]}));
                end
            end
            qau_pkg::MODE_CONJ:
            begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++)
                begin
                    r[i] = sat_h(ext33(33'd0 - {a[i][31], a[i]}));
                end
            end
            qau_pkg::MODE_LEN:      mag = side4_reg.mag;
            qau_pkg::MODE_LENSQ:    mag = side4_reg.mag;
            default:                r = '0;
        endcase
        res5_next.r_w         = r[0];
        res5_next.r_x         = r[1];
        res5_next.r_y         = r[2];
        res5_next.r_z         = r[3];
        res5_next.magnitude   = mag;
        res5_next.zero_divide = side4_reg.zd;
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= op_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v_sq;
            v4_reg <= v_dv;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg      <= op;
            op1_reg      <= op0_reg;
            sqa_reg      <= sqa_next;
            sqb_reg      <= sqb_next;
            side2_reg    <= side2_next;
            t2_reg       <= t2_next;
            side3_reg    <= side3_next;
            dmag_reg     <= dmag_next;
            dneg_reg     <= dneg_next;
            dden_reg     <= dden_next;
            dden_neg_reg <= dden_neg_next;
            side4_reg    <= side_dv;
            q4_reg       <= dq;
            pr_reg       <= pr_next;
            res5_reg     <= res5_next;
        end
    end

    // ---------------- output skid ----------------
    // a result not taken moves into the skid register and freezes the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (v5_reg && !res_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && v5_reg && !res_ready)
        begin
            skid_reg <= res5_reg;
        end
    end

    assign res_valid = skid_valid_reg || v5_reg;
    assign res       = skid_valid_reg ? skid_reg : res5_reg;

    // ---------------- assertions ----------------
    a_zd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.zero_divide |->
            res.r_w == 0 && res.r_x == 0 && res.r_y == 0 && res.r_z == 0 &&
            res.magnitude == 0)
        else $error("zero-divide transaction with non-zero result");

    a_mag_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.magnitude != 0 |->
            res.r_w == 0 && res.r_x == 0 && res.r_y == 0 && res.r_z == 0)
        else $error("magnitude and quaternion both non-zero");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(v5_reg) && $stable(v4_reg))
        else $error("pipeline moved while skid register full");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> v0_reg)
        else $error("accepted transaction lost at input stage");

endmodule

`default_nettype wire

>>> hw/rtl/qau_sqrt_pipe.sv
`default_nettype none

// Integer square root of a 64-bit value, one root bit per stage.
module qau_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_t,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RB = 32;

    logic [RB-1:0]     v_reg;
    logic [32:0]       r_reg    [RB];
    logic [31:0]       q_reg    [RB];
    logic [63:0]       t_reg    [RB];
    logic [SIDE_W-1:0] side_reg [RB];

    logic [32:0]       r_next   [RB];
    logic [31:0]       q_next   [RB];
    logic [63:0]       t_next   [RB];

    always_comb
    begin
        logic [32:0] r_in;
        logic [31:0] q_in;
        logic [63:0] t_in;
        logic [34:0] rs;
        logic [34:0] trial;
        logic [34:0] diff;
        logic        ge;
        for (int k = 0; k < RB; k++)
        begin
            if (k == 0)
            begin
                r_in = '0;
                q_in = '0;
                t_in = in_t;
            end
            else
            begin
                r_in = r_reg[k-1];
                q_in = q_reg[k-1];
                t_in = t_reg[k-1];
            end
            rs        = {r_in, t_in[63:62]};
            trial     = {1'b0, q_in, 2'b01};
            diff      = rs - trial;
            ge        = (rs >= trial);
            r_next[k] = ge ? diff[32:0] : rs[32:0];
            q_next[k] = {q_in[30:0], ge};
            t_next[k] = {t_in[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RB-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RB; k++)
            begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
                t_reg[k] <= t_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = v_reg[RB-1];
    assign out_root  = q_reg[RB-1];
    assign out_side  = side_reg[RB-1];

endmodule

`default_nettype wire

>>> hw/rtl/qau_div_pipe.sv
`default_nettype none

// Four-lane restoring divider with a shared divisor: (num * 2^F) / den,
// truncated, saturated to signed 32 bits. One quotient bit per stage, between a setup stage and a result stage.
module qau_div_pipe #(
    parameter int F      = 16,
    parameter int DW     = 49,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [3:0][31:0]  in_num_mag,
    input  logic [3:0]        in_num_neg,
    input  logic [DW-1:0]     in_den,
    input  logic              in_den_neg,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [3:0][31:0]  out_q,
    output logic [SIDE_W-1:0] out_side
);

    localparam int QB = 32;
    localparam int NL = 4;

    logic [QB+1:0]     v_reg;
    logic [SIDE_W-1:0] side_reg [QB+2];
    logic [DW-1:0]     den_reg  [QB+1];
    logic [DW-1:0]     rem_reg  [NL][QB+1];
    logic [31:0]       sh_reg   [NL][QB+1];
    logic [NL-1:0]     ovf_reg  [QB+1];
    logic [NL-1:0]     neg_reg  [QB+1];
    logic [3:0][31:0]  res_reg;

    logic [DW-1:0]     rem_next [NL][QB+1];
    logic [31:0]       sh_next  [NL][QB+1];
    logic [NL-1:0]     ovf0;
    logic [3:0][31:0]  res_next;

    always_comb
    begin
        logic [31+F:0] nfull;
        logic [DW-1:0] hi;
        logic [DW:0]   rs;
        logic [DW:0]   diff;
        logic          ge;
        for (int l = 0; l < NL; l++)
        begin
            // setup: top part of the scaled numerator, overflow when q >= 2^32
            nfull            = {in_num_mag[l], {F{1'b0}}};
            hi               = DW'(nfull[31+F:32]);
            ovf0[l]          = (hi >= in_den);
            rem_next[l][0]   = hi;
            sh_next[l][0]    = nfull[31:0];
            for (int k = 1; k <= QB; k++)
            begin
                rs   = {rem_reg[l][k-1], sh_reg[l][k-1][31]};
                diff = rs - {1'b0, den_reg[k-1]};
                ge   = (rs >= {1'b0, den_reg[k-1]});
                rem_next[l][k] = ge ? diff[DW-1:0] : rs[DW-1:0];
                sh_next[l][k]  = {sh_reg[l][k-1][30:0], ge};
            end
            // quotient now fills the shift register
            if (neg_reg[QB][l])
            begin
                res_next[l] = (ovf_reg[QB][l] || sh_reg[l][QB][31]) ? qau_pkg::SAT_MIN
                                                                   : (~sh_reg[l][QB] + 32'd1);
            end
            else
            begin
                res_next[l] = (ovf_reg[QB][l] || sh_reg[l][QB][31]) ? qau_pkg::SAT_MAX
                                                                   : sh_reg[l][QB];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QB:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= in_den;
            ovf_reg[0]  <= ovf0;
            neg_reg[0]  <= in_num_neg ^ {NL{in_den_neg}};
            side_reg[0] <= in_side;
            for (int k = 1; k <= QB; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 1; k <= QB+1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < NL; l++)
            begin
                for (int k = 0; k <= QB; k++)
                begin
                    rem_reg[l][k] <= rem_next[l][k];
                    sh_reg[l][k]  <= sh_next[l][k];
                end
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[QB+1];
    assign out_q     = res_reg;
    assign out_side  = side_reg[QB+1];

endmodule

`default_nettype wire

>>> sim/qau_checker.sv
`timescale 1ns / 1ps

module qau_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               op_valid,
    input  wire logic               op_ready,
    input  wire qau_pkg::op_item_t  op,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire qau_pkg::res_item_t res,
    output int                      fail_count,
    output int                      pending_count,
    output int                      zd_seen
);

    typedef struct {
        longint w;
        longint x;
        longint y;
        longint z;
    } quat_t;

    qau_pkg::res_item_t expected_q[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // product rounded toward minus infinity; >>> on a signed value floors
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    // truncating division of the scaled numerator
    function automatic longint qdiv(longint num, longint den);
        longint sn;
        sn = num * (longint'(1) << FRAC_BITS);
        return clamp32(sn / den);
    endfunction

    function automatic quat_t hprod(quat_t a, quat_t b);
        quat_t r;
        r.w = clamp32(qmul(a.w, b.w) - qmul(a.x, b.x) - qmul(a.y, b.y) - qmul(a.z, b.z));
        r.x = clamp32(qmul(a.y, b.z) - qmul(a.z, b.y) + qmul(a.w, b.x) + qmul(a.x, b.w));
        r.y = clamp32(qmul(a.z, b.x) - qmul(a.x, b.z) + qmul(a.w, b.y) + qmul(a.y, b.w));
        r.z = clamp32(qmul(a.x, b.y) - qmul(a.y, b.x) + qmul(a.w, b.z) + qmul(a.z, b.w));
        return r;
    endfunction

    function automatic longint sq_norm(quat_t a);
        return qmul(a.w, a.w) + qmul(a.x, a.x) + qmul(a.y, a.y) + qmul(a.z, a.z);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] length_of(quat_t a);
        logic [63:0] n;
        logic [63:0] t;
        n = sq_norm(a);
        if (n > ({64{1'b1}} >> FRAC_BITS))
            t = {64{1'b1}};
        else
            t = n << FRAC_BITS;
        return root64(t);
    endfunction

    function automatic quat_t conj_over(quat_t a, longint den);
        quat_t r;
        r.w = qdiv(a.w, den);
        r.x = qdiv(-a.x, den);
        r.y = qdiv(-a.y, den);
        r.z = qdiv(-a.z, den);
        return r;
    endfunction

    function automatic qau_pkg::res_item_t quat_result(qau_pkg::op_item_t t);
        quat_t              a;
        quat_t              b;
        quat_t              r;
        longint             s;
        longint             n;
        logic [63:0]        len;
        longint             mag;
        logic               zd;
        qau_pkg::res_item_t o;
        a.w = t.a_w; a.x = t.a_x; a.y = t.a_y; a.z = t.a_z;
        b.w = t.b_w; b.x = t.b_x; b.y = t.b_y; b.z = t.b_z;
        s = t.scale;
        r = '{0, 0, 0, 0};
        mag = 0;
        zd = 1'b0;
        case (t.mode)
            qau_pkg::MODE_ADD:
                r = '{clamp32(a.w + b.w), clamp32(a.x + b.x),
                      clamp32(a.y + b.y), clamp32(a.z + b.z)};
            qau_pkg::MODE_SUB:
                r = '{clamp32(a.w - b.w), clamp32(a.x - b.x),
                      clamp32(a.y - b.y), clamp32(a.z - b.z)};
            qau_pkg::MODE_MUL:
                r = hprod(a, b);
            qau_pkg::MODE_DIV:
            begin
                n = sq_norm(b);
                if (n == 0)
                    zd = 1'b1;
                else
                    r = hprod(a, conj_over(b, n));
            end
            qau_pkg::MODE_SCALE:
                r = '{clamp32(qmul(a.w, s)), clamp32(qmul(a.x, s)),
                      clamp32(qmul(a.y, s)), clamp32(qmul(a.z, s))};
            qau_pkg::MODE_SCALEDIV:
            begin
                if (s == 0)
                    zd = 1'b1;
                else
                    r = '{qdiv(a.w, s), qdiv(a.x, s), qdiv(a.y, s), qdiv(a.z, s)};
            end
            qau_pkg::MODE_NEG:
                r = '{clamp32(-a.w), clamp32(-a.x), clamp32(-a.y), clamp32(-a.z)};
            qau_pkg::MODE_CONJ:
                r = '{a.w, clamp32(-a.x), clamp32(-a.y), clamp32(-a.z)};
            qau_pkg::MODE_INV:
            begin
                n = sq_norm(a);
                if (n == 0)
                    zd = 1'b1;
                else
                    r = conj_over(a, n);
            end
            qau_pkg::MODE_NORM:
            begin
                len = length_of(a);
                if (len == 0)
                    zd = 1'b1;
                else
                    r = '{qdiv(a.w, len), qdiv(a.x, len), qdiv(a.y, len), qdiv(a.z, len)};
            end
            qau_pkg::MODE_LEN:
            begin
                len = length_of(a);
                mag = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
            end
            qau_pkg::MODE_LENSQ:
            begin
                n = sq_norm(a);
                mag = (n > 64'sd2147483647) ? 64'sd2147483647 : n;
            end
            default:
                ;
        endcase
        o.r_w = r.w[31:0];
        o.r_x = r.x[31:0];
        o.r_y = r.y[31:0];
        o.r_z = r.z[31:0];
        o.magnitude = mag[30:0];
        o.zero_divide = zd;
        return o;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        qau_pkg::res_item_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            zd_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            if (op_valid && op_ready)
                expected_q.push_back(quat_result(op));
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.zero_divide)
                        zd_seen <= zd_seen + 1;
                    if (res.r_w !== e.r_w)
                        $error("r_w: expected %0d, got %0d", e.r_w, res.r_w);
                    if (res.r_x !== e.r_x)
                        $error("r_x: expected %0d, got %0d", e.r_x, res.r_x);
                    if (res.r_y !== e.r_y)
                        $error("r_y: expected %0d, got %0d", e.r_y, res.r_y);
                    if (res.r_z !== e.r_z)
                        $error("r_z: expected %0d, got %0d", e.r_z, res.r_z);
                    if (res.magnitude !== e.magnitude)
                        $error("magnitude: expected %0d, got %0d",
                               e.magnitude, res.magnitude);
                    if (res.zero_divide !== e.zero_divide)
                        $error("zero_divide: expected %0b, got %0b",
                               e.zero_divide, res.zero_divide);
                    if (res !== e)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

>>> sim/quaternion_arithmetic_unit_test.sv
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_test;

    // below the pipeline latency; the drain wait allows margin over it
    localparam int LATENCY     = 71;
    localparam int DRAIN_WAIT  = 2 * LATENCY;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1900;

    logic               clk;
    logic               rst_n;
    logic               op_valid;
    logic               op_ready;
    qau_pkg::op_item_t  op;
    logic               res_valid;
    logic               res_ready;
    qau_pkg::res_item_t res;
    int                 fail_count;
    int                 pending_count;
    int                 zd_seen;
    int                 sent;
    int                 idle_cycles;
    logic               quiet_phase;   // no idling on either side while set

    quaternion_arithmetic_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    qau_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .zd_seen       (zd_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((op_valid && op_ready) || (res_valid && res_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random back-pressure with probability 31 in 100, none while quiet_phase is set
    always @(negedge clk)
    begin
        if (quiet_phase)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= 31);
    end

    // wide-ranging random value: extremes, small values, near one, or raw bits
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(600)) - 300);
            3: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
            4: return 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic qau_pkg::op_item_t random_item();
        qau_pkg::op_item_t t;
        t.mode  = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                            : 4'($urandom_range(11));
        t.a_w   = pick_value();
        t.a_x   = pick_value();
        t.a_y   = pick_value();
        t.a_z   = pick_value();
        t.b_w   = pick_value();
        t.b_x   = pick_value();
        t.b_y   = pick_value();
        t.b_z   = pick_value();
        t.scale = ($urandom_range(15) == 0) ? 32'd0 : pick_value();
        // sometimes a tiny quaternion whose squares round away
        if ($urandom_range(15) == 0)
        begin
            t.a_w = 32'($urandom_range(255)); t.a_x = 32'($urandom_range(255));
            t.a_y = 32'($urandom_range(255)); t.a_z = 32'($urandom_range(255));
        end
        if ($urandom_range(15) == 0)
        begin
            t.b_w = 32'($urandom_range(255)); t.b_x = 32'($urandom_range(255));
            t.b_y = 32'($urandom_range(255)); t.b_z = 32'($urandom_range(255));
        end
        return t;
    endfunction

    // one transaction; sender idles at random unless quiet_phase is set.
    // Called at a falling edge, returns at the falling edge after acceptance
    // with op_valid still high.
    task automatic send_item(qau_pkg::op_item_t t);
        while (!quiet_phase && $urandom_range(99) < 31)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op_valid <= 1'b1;
        op <= t;
        @(posedge clk);
        while (!op_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_quat(qau_pkg::mode_t m, logic [31:0] aw, logic [31:0] ax,
                             logic [31:0] ay, logic [31:0] az, logic [31:0] bw,
                             logic [31:0] s);
        qau_pkg::op_item_t t;
        t = '{m, aw, ax, ay, az, bw, ax, ay, az, s};
        send_item(t);
    endtask

    initial
    begin
        qau_pkg::op_item_t t;
        rst_n       = 1'b0;
        op_valid    = 1'b0;
        op          = '0;
        quiet_phase = 1'b0;
        sent        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: each operation with ordinary and saturating operands
        send_quat(qau_pkg::MODE_ADD,  32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                  32'hffff_0000, 32'h0000_0001, 32'h0001_0000);
        send_quat(qau_pkg::MODE_SUB,  32'h8000_0000, 32'h7fff_ffff, 32'h0002_0000, 32'h0,
                  32'h0000_0001, 32'h0001_0000);
        send_quat(qau_pkg::MODE_MUL,  32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0004_0000, 32'h0000_8000, 32'h0);
        send_quat(qau_pkg::MODE_MUL,  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_quat(qau_pkg::MODE_DIV,  32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0001_0000,
                  32'h0002_0000, 32'h0);
        // zero divisor: B all zero
        t = '{qau_pkg::MODE_DIV, 32'h0001_0000, 32'h1, 32'h2, 32'h3,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        send_item(t);
        // tiny B: squares round to zero
        t = '{qau_pkg::MODE_DIV, 32'h0001_0000, 32'h1, 32'h2, 32'h3,
              32'h5, 32'h7, 32'hff, 32'h1, 32'h0};
        send_item(t);
        send_quat(qau_pkg::MODE_SCALE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                  32'h0001_0000, 32'h0, 32'h7fff_ffff);
        send_quat(qau_pkg::MODE_SCALE, 32'h0001_0000, 32'h8000_0000, 32'h3, 32'hfff0_0000,
                  32'h0, 32'h8000_0000);
        send_quat(qau_pkg::MODE_SCALEDIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000,
                  32'hffff_fffd, 32'h0, 32'h0000_0001);
        send_quat(qau_pkg::MODE_SCALEDIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h1,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_NEG,  32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_INV,  32'h0002_0000, 32'h0, 32'hffff_0000, 32'h0,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_INV,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_INV,  32'h10, 32'h20, 32'h0, 32'h1, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_NORM, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_NORM, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_LEN,  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_LEN,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_quat(qau_pkg::MODE_LENSQ, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                  32'h0, 32'h0);
        send_quat(qau_pkg::MODE_LENSQ, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        t = '{4'd15, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9};
        send_item(t);
        op_valid <= 1'b0;

        // hold off until everything directed has drained
        wait (pending_count == 0);
        @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a burst with no idling on either side
            if (i == 600)
                quiet_phase = 1'b1;
            if (i == 900)
                quiet_phase = 1'b0;
            send_item(random_item());
        end
        op_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d transactions over all operations, including %0d", sent, zd_seen);
        $display("zero-divisor results, saturating operands and back-pressure.");
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
